[hw/rtl/slfr_pkg.sv]
// Package for the signal lamp frame receiver: parse phases, frame constants, channel decode.
`default_nettype none

package slfr_pkg;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEAD   = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  localparam logic [7:0]  BinHeader   = 8'hAA;
  localparam logic [7:0]  AsciiHead0  = 8'h5A;
  localparam logic [7:0]  AsciiHead1  = 8'h46;
  localparam logic [23:0] CmdRed      = 24'h524544;
  localparam logic [23:0] CmdSht      = 24'h534854;
  localparam logic [2:0]  ChanSlot    = 3'd1;
  localparam logic [2:0]  TextFirst   = 3'd2;
  localparam logic [2:0]  TextLast    = 3'd4;
  localparam logic [2:0]  PayloadLast = 3'd6;

  localparam logic [7:0]  CharZero    = 8'h30;
  localparam logic [7:0]  CharNine    = 8'h39;
  localparam logic [7:0]  CharThree   = 8'h33;

  // Lamp bit picked by a channel character; non-digits pick channel 0.
  function automatic logic [7:0] channel_bit(input logic [7:0] c);
    logic [7:0] d;
    d = c - CharZero;
    if (c >= CharZero && c <= CharNine) begin
      if (c <= CharThree) begin
        channel_bit = 8'd1 << d[1:0];
      end else begin
        channel_bit = 8'd0;
      end
    end else begin
      channel_bit = 8'd1;
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/signal_lamp_frame_receiver.sv]
// Signal lamp frame receiver: binary checksum and ASCII command frame parser.
// An accepted byte goes through the input register, then the result register.
// Throughput: one byte per cycle unless the output stalls; the two registers
// form a two-stage pipeline and the parser state updates in a single pass.
// Reset: asynchronous active-low; clears the mode, the parser and the lamp mask,
// and empties both stages.
`default_nettype none

module signal_lamp_frame_receiver
  import slfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      signal_mask_o,
  output logic            frame_ok_o,
  output logic            checksum_error_o
);

  logic        mode_q;
  phase_e      phase_q, phase_d;
  logic [2:0]  count_q, count_d;
  logic [7:0]  data_q, data_d;
  logic [7:0]  chan_q, chan_d;
  logic [23:0] text_q, text_d;
  logic [7:0]  lamp_q, lamp_d;

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;

  logic        out_valid_q;
  logic [7:0]  out_mask_q;
  logic        out_ok_q, out_err_q;

  logic        out_hold;
  logic        advance;
  logic        ok_d, err_d;
  logic [7:0]  chan_bit;

  assign out_hold   = out_valid_q & out_stall_i;
  assign advance    = s1_valid_q & ~out_hold;
  assign in_stall_o = s1_valid_q & out_hold;

  // Parse one byte against the current state.
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    data_d   = data_q;
    chan_d   = chan_q;
    text_d   = text_q;
    lamp_d   = lamp_q;
    ok_d     = 1'b0;
    err_d    = 1'b0;
    chan_bit = 8'd0;
    if (!mode_q) begin
      unique case (phase_q)
        PH_HEAD: begin
          data_d  = s1_byte_q;
          phase_d = PH_BODY;
        end
        PH_BODY: begin
          if (8'(BinHeader + data_q) == s1_byte_q) begin
            lamp_d = data_q;
            ok_d   = 1'b1;
          end else begin
            err_d = 1'b1;
          end
          phase_d = PH_HUNT;
          count_d = 3'd0;
        end
        default: begin
          phase_d = (s1_byte_q == BinHeader) ? PH_HEAD : PH_HUNT;
        end
      endcase
    end else begin
      unique case (phase_q)
        PH_HEAD: begin
          phase_d = (s1_byte_q == AsciiHead1) ? PH_BODY : PH_HUNT;
          count_d = 3'd0;
        end
        PH_BODY: begin
          if (count_q == ChanSlot) begin
            chan_d = s1_byte_q;
          end else if (count_q >= TextFirst && count_q <= TextLast) begin
            text_d = {text_q[15:0], s1_byte_q};
          end
          chan_bit = channel_bit(chan_d);
          if (count_q >= PayloadLast) begin
            if (text_d == CmdRed) begin
              lamp_d = lamp_q | chan_bit;
              ok_d   = 1'b1;
            end else if (text_d == CmdSht) begin
              lamp_d = lamp_q & ~chan_bit;
              ok_d   = 1'b1;
            end
            phase_d = PH_HUNT;
            count_d = 3'd0;
          end else begin
            count_d = count_q + 3'd1;
          end
        end
        default: begin
          phase_d = (s1_byte_q == AsciiHead0) ? PH_HEAD : PH_HUNT;
          count_d = 3'd0;
        end
      endcase
    end
  end

  // Parser state; a mode write restarts the hunt and keeps the mask.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      phase_q <= PH_HUNT;
      count_q <= 3'd0;
      data_q  <= 8'd0;
      chan_q  <= 8'd0;
      text_q  <= 24'd0;
      lamp_q  <= 8'd0;
    end else if (cfg_we_i) begin
      mode_q  <= cfg_wdata_i;
      phase_q <= PH_HUNT;
      count_q <= 3'd0;
    end else if (advance) begin
      phase_q <= phase_d;
      count_q <= count_d;
      data_q  <= data_d;
      chan_q  <= chan_d;
      text_q  <= text_d;
      lamp_q  <= lamp_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_mask_q <= lamp_d;
      out_ok_q   <= ok_d;
      out_err_q  <= err_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign signal_mask_o    = out_mask_q;
  assign frame_ok_o       = out_ok_q;
  assign checksum_error_o = out_err_q;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_ok_o && checksum_error_o))
    else $error("frame_ok and checksum_error both set");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled while a stage is free");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= PayloadLast)
    else $error("payload count past frame end");

  a_no_ascii_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && mode_q && !cfg_we_i) |=> (out_valid_q && !out_err_q))
    else $error("checksum error raised in ASCII mode");

endmodule

`default_nettype wire

[tb/signal_lamp_frame_receiver_tb.sv]
// Testbench for the signal lamp frame receiver: directed and random byte streams, checked word by word.
module signal_lamp_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slfr_pkg::*;

  typedef struct packed {
    logic [7:0] mask;
    logic       ok;
    logic       err;
  } lamp_report_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] signal_mask_o;
  logic       frame_ok_o;
  logic       checksum_error_o;

  signal_lamp_frame_receiver i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .signal_mask_o    (signal_mask_o),
    .frame_ok_o       (frame_ok_o),
    .checksum_error_o (checksum_error_o)
  );

  // Lamp state predictor
  logic        mode_ascii;
  phase_e      hunt_phase;
  logic [2:0]  body_count;
  logic [7:0]  held_data;
  logic [7:0]  held_chan;
  logic [23:0] held_cmd;
  logic [7:0]  lamps;

  lamp_report_t pending_reports[$];

  int idle_pct;
  int stall_pct;
  int hold_left;
  int bytes_sent;
  int words_checked;
  int ok_seen;
  int err_seen;
  int mode_writes;
  int in_hold_cycles;
  int mismatches;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] lamp_for_channel(input logic [7:0] c);
    if (c >= CharZero && c <= CharNine) begin
      if (c <= CharThree) begin
        return 8'd1 << (c - CharZero);
      end
      return 8'd0;
    end
    return 8'd1;
  endfunction

  function automatic void restart_hunt();
    hunt_phase = PH_HUNT;
    body_count = 3'd0;
  endfunction

  // Advance the parser by one byte and queue the word it produces.
  function automatic void decode_byte(input logic [7:0] b);
    lamp_report_t rep;
    logic [7:0]   sum;
    rep = '0;
    if (!mode_ascii) begin
      case (hunt_phase)
        PH_HEAD: begin
          held_data  = b;
          hunt_phase = PH_BODY;
        end
        PH_BODY: begin
          sum = BinHeader + held_data;
          if (sum == b) begin
            lamps  = held_data;
            rep.ok = 1'b1;
          end else begin
            rep.err = 1'b1;
          end
          restart_hunt();
        end
        default: begin
          if (b == BinHeader) hunt_phase = PH_HEAD;
          else hunt_phase = PH_HUNT;
        end
      endcase
    end else begin
      case (hunt_phase)
        PH_HEAD: begin
          if (b == AsciiHead1) begin
            hunt_phase = PH_BODY;
            body_count = 3'd0;
          end else begin
            restart_hunt();
          end
        end
        PH_BODY: begin
          if (body_count == ChanSlot) begin
            held_chan = b;
          end else if (body_count >= TextFirst && body_count <= TextLast) begin
            held_cmd = {held_cmd[15:0], b};
          end
          if (body_count >= PayloadLast) begin
            if (held_cmd == CmdRed) begin
              lamps  = lamps | lamp_for_channel(held_chan);
              rep.ok = 1'b1;
            end else if (held_cmd == CmdSht) begin
              lamps  = lamps & ~lamp_for_channel(held_chan);
              rep.ok = 1'b1;
            end
            restart_hunt();
          end else begin
            body_count = body_count + 3'd1;
          end
        end
        default: begin
          if (b == AsciiHead0) hunt_phase = PH_HEAD;
          else hunt_phase = PH_HUNT;
          body_count = 3'd0;
        end
      endcase
    end
    rep.mask = lamps;
    pending_reports.push_back(rep);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Receiver side: hold off on request, otherwise stall at random.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    lamp_report_t want;
    if (rst_ni && in_valid_i && in_stall_o) in_hold_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected word, mask", int'(signal_mask_o), 0);
      end else begin
        want = pending_reports.pop_front();
        if (signal_mask_o !== want.mask) begin
          report_mismatch("signal_mask", int'(signal_mask_o), int'(want.mask));
        end
        if (frame_ok_o !== want.ok) begin
          report_mismatch("frame_ok", int'(frame_ok_o), int'(want.ok));
        end
        if (checksum_error_o !== want.err) begin
          report_mismatch("checksum_error", int'(checksum_error_o), int'(want.err));
        end
        words_checked++;
        if (want.ok) ok_seen++;
        if (want.err) err_seen++;
      end
    end
  end

  // Offer one byte after a random gap; return at the edge that takes it.
  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b);
    bytes_sent++;
  endtask

  // Drop valid, drain, then write the mode register.
  task automatic write_mode(input logic m);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    mode_ascii = m;
    restart_hunt();
    mode_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_bin_frame(input logic [7:0] data, input logic good);
    logic [7:0] sum;
    sum = BinHeader + data;
    send_word(BinHeader);
    send_word(data);
    if (good) send_word(sum);
    else send_word(8'($urandom_range(255)));
  endtask

  task automatic send_ascii_frame(input logic [7:0] chan, input logic [23:0] cmd);
    send_word(AsciiHead0);
    send_word(AsciiHead1);
    send_word(8'($urandom_range(255)));
    send_word(chan);
    send_word(cmd[23:16]);
    send_word(cmd[15:8]);
    send_word(cmd[7:0]);
    send_word(8'($urandom_range(255)));
    send_word(8'($urandom_range(255)));
  endtask

  task automatic test_binary_frames();
    send_bin_frame(8'h00, 1'b1);
    send_bin_frame(8'hFF, 1'b1);
    // bad checksum keeps the mask
    send_word(BinHeader);
    send_word(8'h55);
    send_word(8'h00);
    send_word(8'h00);
    // header byte taken as data inside a frame
    send_bin_frame(BinHeader, 1'b1);
  endtask

  task automatic test_ascii_frames();
    write_mode(1'b1);
    send_ascii_frame(CharZero, CmdRed);
    // second Z after Z is consumed, so the F that follows is just noise
    send_word(AsciiHead0);
    send_word(AsciiHead0);
    send_word(AsciiHead1);
    send_ascii_frame(8'h41, CmdSht);
  endtask

  task automatic test_mode_rewrite();
    write_mode(1'b0);
    send_word(BinHeader);
    write_mode(1'b0);
    send_word(8'h00);
    send_word(BinHeader);
    send_word(8'h00);
    send_word(BinHeader);
    write_mode(1'b1);
    send_word(AsciiHead0);
    send_word(AsciiHead1);
    send_word(8'h00);
    send_word(CharThree);
    write_mode(1'b1);
    send_word(CmdRed[23:16]);
    send_word(CmdRed[15:8]);
    send_word(CmdRed[7:0]);
  endtask

  task automatic test_backpressure();
    int stop_at;
    write_mode(1'b0);
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk_i);
    hold_left = 150;
    stop_at = bytes_sent + 60;
    while (bytes_sent < stop_at) send_bin_frame(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic random_burst(input int n_bytes);
    int          stop_at;
    int          pick;
    logic [7:0]  chan;
    logic [23:0] cmd;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (!mode_ascii) begin
        if (pick < 75) send_bin_frame(8'($urandom_range(255)), 1'b1);
        else if (pick < 90) send_bin_frame(8'($urandom_range(255)), 1'b0);
        else send_word(8'($urandom_range(255)));
      end else if (pick < 70) begin
        if ($urandom_range(99) < 65) chan = 8'($urandom_range(CharNine, CharZero));
        else chan = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 45) cmd = CmdRed;
        else if (pick < 85) cmd = CmdSht;
        else if (pick < 93) cmd = CmdRed ^ (24'd1 << $urandom_range(23));
        else cmd = 24'($urandom_range(24'hFFFFFF));
        send_ascii_frame(chan, cmd);
      end else if (pick < 85) begin
        // broken header
        send_word(AsciiHead0);
        if ($urandom_range(1)) send_word(AsciiHead0);
        else send_word(8'($urandom_range(255)));
      end else begin
        send_word(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_random_streams();
    int idle_set[4];
    int stall_set[4];
    idle_set  = '{0, 70, 0, 26};
    stall_set = '{0, 0, 70, 26};
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      for (int k = 0; k < 4; k++) begin
        write_mode(k[0]);
        random_burst(50);
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    out_stall_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_left   = 0;
    mode_ascii  = 1'b0;
    hunt_phase  = PH_HUNT;
    body_count  = 3'd0;
    held_data   = 8'h00;
    held_chan   = 8'h00;
    held_cmd    = 24'h0;
    lamps       = 8'h00;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_binary_frames();
    test_ascii_frames();
    test_mode_rewrite();
    test_backpressure();
    test_random_streams();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes in both frame modes over %0d mode writes; checked %0d words.",
             bytes_sent, mode_writes, words_checked);
    $display("Saw %0d accepted frames, %0d checksum errors, input held back %0d cycles.",
             ok_seen, err_seen, in_hold_cycles);
    if (mismatches == 0) begin
      $display("signal_lamp_frame_receiver test passed");
    end else begin
      $display("signal_lamp_frame_receiver test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("signal_lamp_frame_receiver test failed");
    $finish;
  end

endmodule

[signal_lamp_frame_receiver.f]
hw/rtl/slfr_pkg.sv
hw/rtl/signal_lamp_frame_receiver.sv
tb/signal_lamp_frame_receiver_tb.sv
